FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and helpers for the rational arithmetic unit
// Word widths, request codes, sequencer states and sign/magnitude helpers.
// ----------------------------------------------------------------------------
package rau_pkg;

   // internal arithmetic width, products and sums wrap at this width
   localparam int WIDTH   = 32;
   // width of the numeric fields on the channels
   localparam int FIELD_W = 32;
   // width of the request code field
   localparam int OP_W    = 4;
   // bit counter of the serial divider, holds WIDTH itself
   localparam int CNT_W   = $clog2(WIDTH + 1);
   // common power-of-two count of the binary gcd
   localparam int SHIFT_W = $clog2(WIDTH);

   typedef logic [WIDTH-1:0] rau_word_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_MULI = 4'd4,
      OP_NEG  = 4'd5,
      OP_EQ   = 4'd6,
      OP_LT   = 4'd7,
      OP_GE   = 4'd8
   } rau_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_LOAD,
      ST_GCD,
      ST_DIVN_GO,
      ST_DIVN,
      ST_DIVD_GO,
      ST_DIVD,
      ST_FIN
   } rau_state_type;

   // status of a multi-cycle unit as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } rau_unit_stat_type;

   // absolute value as unsigned, the most negative value maps to 2^(WIDTH-1)
   function automatic rau_word_type magnitude(input rau_word_type x);
      return x[WIDTH-1] ? ((~x) + rau_word_type'(1)) : x;
   endfunction

   // field word to internal width, truncated or sign extended
   function automatic rau_word_type to_word(input logic [FIELD_W-1:0] x);
      return WIDTH'(signed'(x));
   endfunction

   // internal word to field width, truncated or sign extended
   function automatic logic [FIELD_W-1:0] to_field(input rau_word_type x);
      return FIELD_W'(signed'(x));
   endfunction

   // requests whose result goes through gcd reduction
   function automatic logic is_reducible(input rau_op_type op);
      return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
             (op == OP_DIV) || (op == OP_MULI);
   endfunction

endpackage

FILE: rtl/rau_req_if.sv
// ----------------------------------------------------------------------------
// rau_req_if: request channel of the rational arithmetic unit
// Valid/ready channel carrying the request code and two fractions.
// ----------------------------------------------------------------------------
interface rau_req_if;
   logic                                valid;
   logic                                ready;
   logic [rau_pkg::OP_W-1:0]            req_type;
   logic signed [rau_pkg::FIELD_W-1:0]  a_num;
   logic signed [rau_pkg::FIELD_W-1:0]  a_den;
   logic signed [rau_pkg::FIELD_W-1:0]  b_num;
   logic signed [rau_pkg::FIELD_W-1:0]  b_den;

   modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: rtl/rau_rsp_if.sv
// ----------------------------------------------------------------------------
// rau_rsp_if: response channel of the rational arithmetic unit
// Valid/ready channel carrying the reduced fraction and the flags.
// ----------------------------------------------------------------------------
interface rau_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rau_pkg::FIELD_W-1:0]  res_num;
   logic signed [rau_pkg::FIELD_W-1:0]  res_den;
   logic                                cmp_true;
   logic                                zero_den_error;

   modport source (output valid, res_num, res_den, cmp_true, zero_den_error, input ready);
   modport sink   (input valid, res_num, res_den, cmp_true, zero_den_error, output ready);
endinterface

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic with gcd reduction
// A sequencer drives one shared multiplier, a binary gcd unit and a serial
// divider to add, subtract, multiply, divide, negate and compare fractions.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+------------------------------------------
//  req     | in  | valid / ready | req_type, a_num, a_den, b_num, b_den
//  rsp     | out | valid / ready | res_num, res_den, cmp_true, zero_den_error
//
//  neg, comparisons and unreduced results pass from accept through the MUL,
//  EVAL, LOAD and FIN states to the response register; reduced results add
//  the GCD state and two serial divisions (DIVN and DIVD) before FIN.
//  The gcd loop and the one-bit-per-cycle divider set the time of a reduced result.
//  req.ready is high only while the sequencer is idle; the response register
//  holds a word while rsp.ready is low and one more request is still taken,
//  which then waits in ST_FIN until that word leaves. Synchronous active-high
//  reset clears the sequencer, the unit flags and the response valid flag.
//
module rational_arithmetic_unit (
   input  logic clock,
   input  logic reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);

   rau_pkg::rau_state_type          state_ff, state_in;
   rau_pkg::rau_op_type             op_ff;
   rau_pkg::rau_word_type           an_ff, ad_ff, bn_ff, bd_ff;
   rau_pkg::rau_word_type           prod_ff [3];
   logic [1:0]                      step_ff, step_in;
   rau_pkg::rau_word_type           num_ff, num_in;
   rau_pkg::rau_word_type           den_ff, den_in;
   logic                            cmp_ff, cmp_in;
   logic                            err_ff, err_in;
   rau_pkg::rau_word_type           g_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rau_pkg::FIELD_W-1:0]     res_num_ff, res_den_ff;
   logic                            res_cmp_ff, res_err_ff;
   logic                            rsp_load;

   rau_pkg::rau_word_type           mul_x, mul_y, mul_p;
   rau_pkg::rau_word_type           num_mag, den_mag;
   logic                            reduce_go;
   logic                            accept;

   logic                            gcd_start;
   rau_pkg::rau_unit_stat_type      gcd_stat;
   rau_pkg::rau_word_type           gcd_g;

   logic                            div_start;
   rau_pkg::rau_word_type           div_dividend;
   rau_pkg::rau_unit_stat_type      div_stat;
   rau_pkg::rau_word_type           div_q;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == rau_pkg::ST_IDLE);

   // magnitudes of the unreduced result
   assign num_mag   = rau_pkg::magnitude(num_ff);
   assign den_mag   = rau_pkg::magnitude(den_ff);
   assign reduce_go = rau_pkg::is_reducible(op_ff) && (num_mag != '0) && (den_mag != '0);

   // shared multiplier operand select, one product per step
   always_comb begin
      mul_x = ad_ff;
      mul_y = bd_ff;
      case (step_ff)
         2'd0: begin
            mul_x = an_ff;
            if ((op_ff == rau_pkg::OP_MUL) || (op_ff == rau_pkg::OP_MULI)) begin
               mul_y = bn_ff;
            end else begin
               mul_y = bd_ff;
            end
         end
         2'd1: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         default: begin
            mul_x = ad_ff;
            if ((op_ff == rau_pkg::OP_DIV) || (op_ff == rau_pkg::OP_LT) ||
                (op_ff == rau_pkg::OP_GE)) begin
               mul_y = bn_ff;
            end else if (op_ff == rau_pkg::OP_MULI) begin
               mul_y = rau_pkg::rau_word_type'(1);
            end else begin
               mul_y = bd_ff;
            end
         end
      endcase
   end

   // low half of the product wraps as the integer arithmetic does
   assign mul_p = mul_x * mul_y;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::ST_IDLE:    if (req.valid) state_in = rau_pkg::ST_MUL;
         rau_pkg::ST_MUL:     if (step_ff == 2'd2) state_in = rau_pkg::ST_EVAL;
         rau_pkg::ST_EVAL:    state_in = rau_pkg::ST_LOAD;
         rau_pkg::ST_LOAD: begin
            if (reduce_go) state_in = rau_pkg::ST_GCD;
            else           state_in = rau_pkg::ST_FIN;
         end
         rau_pkg::ST_GCD:     if (gcd_stat.done) state_in = rau_pkg::ST_DIVN_GO;
         rau_pkg::ST_DIVN_GO: state_in = rau_pkg::ST_DIVN;
         rau_pkg::ST_DIVN:    if (div_stat.done) state_in = rau_pkg::ST_DIVD_GO;
         rau_pkg::ST_DIVD_GO: state_in = rau_pkg::ST_DIVD;
         rau_pkg::ST_DIVD:    if (div_stat.done) state_in = rau_pkg::ST_FIN;
         rau_pkg::ST_FIN:     if (!rsp_valid_ff || rsp.ready) state_in = rau_pkg::ST_IDLE;
         default:             state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      step_in      = step_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      cmp_in       = cmp_ff;
      err_in       = err_ff;
      gcd_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = num_mag;
      rsp_load     = 1'b0;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            step_in = 2'd0;
            err_in  = 1'b0;
         end
         rau_pkg::ST_MUL: begin
            step_in = step_ff + 1'b1;
         end
         rau_pkg::ST_EVAL: begin
            num_in = '0;
            den_in = '0;
            cmp_in = 1'b0;
            case (op_ff)
               rau_pkg::OP_ADD: begin
                  num_in = prod_ff[0] + prod_ff[1];
                  den_in = prod_ff[2];
               end
               rau_pkg::OP_SUB: begin
                  num_in = prod_ff[0] - prod_ff[1];
                  den_in = prod_ff[2];
               end
               rau_pkg::OP_MUL, rau_pkg::OP_DIV, rau_pkg::OP_MULI: begin
                  num_in = prod_ff[0];
                  den_in = prod_ff[2];
               end
               rau_pkg::OP_NEG: begin
                  num_in = '0 - an_ff;
                  den_in = ad_ff;
               end
               rau_pkg::OP_EQ: begin
                  cmp_in = (ad_ff == rau_pkg::rau_word_type'(1)) && (an_ff == bn_ff);
               end
               rau_pkg::OP_LT: begin
                  cmp_in = ($signed(an_ff) < $signed(prod_ff[2]));
               end
               rau_pkg::OP_GE: begin
                  cmp_in = !($signed(an_ff) < $signed(prod_ff[2]));
               end
               default: begin
                  cmp_in = 1'b0;
               end
            endcase
         end
         rau_pkg::ST_LOAD: begin
            gcd_start = reduce_go;
            err_in    = rau_pkg::is_reducible(op_ff) && (num_mag != '0) && (den_mag == '0);
         end
         rau_pkg::ST_DIVN_GO: begin
            div_start    = 1'b1;
            div_dividend = num_mag;
         end
         rau_pkg::ST_DIVN: begin
            if (div_stat.done) begin
               num_in = num_ff[rau_pkg::WIDTH-1] ? ('0 - div_q) : div_q;
            end
         end
         rau_pkg::ST_DIVD_GO: begin
            div_start    = 1'b1;
            div_dividend = den_mag;
         end
         rau_pkg::ST_DIVD: begin
            if (div_stat.done) begin
               den_in = den_ff[rau_pkg::WIDTH-1] ? ('0 - div_q) : div_q;
            end
         end
         rau_pkg::ST_FIN: begin
            rsp_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            step_in = 2'd0;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::ST_IDLE;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture, products and working result
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= rau_pkg::rau_op_type'(req.req_type);
         an_ff <= rau_pkg::to_word(req.a_num);
         ad_ff <= rau_pkg::to_word(req.a_den);
         bn_ff <= rau_pkg::to_word(req.b_num);
         bd_ff <= rau_pkg::to_word(req.b_den);
      end
      if (state_ff == rau_pkg::ST_MUL) begin
         prod_ff[step_ff] <= mul_p;
      end
      if (gcd_stat.done) begin
         g_ff <= gcd_g;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      cmp_ff <= cmp_in;
      err_ff <= err_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         res_num_ff <= rau_pkg::to_field(num_ff);
         res_den_ff <= rau_pkg::to_field(den_ff);
         res_cmp_ff <= cmp_ff;
         res_err_ff <= err_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.res_num        = res_num_ff;
   assign rsp.res_den        = res_den_ff;
   assign rsp.cmp_true       = res_cmp_ff;
   assign rsp.zero_den_error = res_err_ff;

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .up    (num_mag),
      .down  (den_mag),
      .stat  (gcd_stat),
      .g     (gcd_g)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

`ifndef SYNTHESIS
   // an error word always carries the zero denominator it reports
   a_err_den_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.zero_den_error) |-> (rsp.res_den == '0))
      else $error("error flag with nonzero denominator");

   // comparison outcome and error flag never appear together
   a_err_not_cmp: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.zero_den_error) |-> !rsp.cmp_true)
      else $error("error flag on a comparison word");

   // the gcd of two nonzero magnitudes is never zero
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      gcd_stat.done |-> (gcd_g != '0))
      else $error("gcd unit finished with zero");

   // the divider is only started when free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!div_stat.busy && !gcd_stat.busy))
      else $error("divider started while a unit is busy");
`endif

endmodule

FILE: rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: binary gcd unit
// One compare, subtract or shift step per cycle on two nonzero magnitudes.
// ----------------------------------------------------------------------------
module rau_gcd (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  rau_pkg::rau_word_type      up,
   input  rau_pkg::rau_word_type      down,
   output rau_pkg::rau_unit_stat_type stat,
   output rau_pkg::rau_word_type      g
);

   rau_pkg::rau_word_type           a_ff, a_in;
   rau_pkg::rau_word_type           b_ff, b_in;
   logic [rau_pkg::SHIFT_W-1:0]     k_ff, k_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   // one gcd step
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = up;
         b_in    = down;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == b_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

   // odd part restored with the common power of two
   assign g         = a_ff << k_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  rau_pkg::rau_word_type      dividend,
   input  rau_pkg::rau_word_type      divisor,
   output rau_pkg::rau_unit_stat_type stat,
   output rau_pkg::rau_word_type      quotient
);

   rau_pkg::rau_word_type           rem_ff, rem_in;
   rau_pkg::rau_word_type           quo_ff, quo_in;
   rau_pkg::rau_word_type           dvs_ff, dvs_in;
   logic [rau_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [rau_pkg::WIDTH:0]         trial;
   logic [rau_pkg::WIDTH:0]         diff;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[rau_pkg::WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = rau_pkg::CNT_W'(rau_pkg::WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[rau_pkg::WIDTH]) begin
            rem_in = diff[rau_pkg::WIDTH-1:0];
            quo_in = {quo_ff[rau_pkg::WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[rau_pkg::WIDTH-1:0];
            quo_in = {quo_ff[rau_pkg::WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// Drives request words over the valid/ready channel, predicts every response
// word with a local model of the wrapped products and the gcd reduction, and
// compares each response field by field. Random gaps on both channels and a
// long response hold-off exercise the flow control.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

   localparam int                  OP_CODE_MAX  = (1 << rau_pkg::OP_W) - 1;
   localparam logic signed [31:0]  MOST_NEG     = 32'sh8000_0000;
   localparam logic signed [31:0]  MOST_POS     = 32'sh7FFF_FFFF;
   localparam int                  STALL_CYCLES = 600;
   localparam int                  DRAIN_CYCLES = 400;
   localparam int                  CYCLE_LIMIT  = 1_000_000;
   localparam int                  RANDOM_WORDS = 620;
   localparam int                  STREAM_WORDS = 100;

   typedef logic [rau_pkg::OP_W-1:0] op_code_type;

   typedef struct packed {
      op_code_type                         code;
      logic signed [rau_pkg::FIELD_W-1:0]  a_num;
      logic signed [rau_pkg::FIELD_W-1:0]  a_den;
      logic signed [rau_pkg::FIELD_W-1:0]  b_num;
      logic signed [rau_pkg::FIELD_W-1:0]  b_den;
   } fraction_req_type;

   typedef struct packed {
      logic signed [rau_pkg::FIELD_W-1:0]  res_num;
      logic signed [rau_pkg::FIELD_W-1:0]  res_den;
      logic                                cmp_true;
      logic                                zero_den_error;
   } fraction_rsp_type;

   logic clock;
   logic reset;

   rau_req_if req_bus ();
   rau_rsp_if rsp_bus ();

   rational_arithmetic_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   fraction_rsp_type pending_results[$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count    = 0;
   bit               free_run       = 1'b0;
   bit               stall_req      = 1'b0;

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // expected response for one request word
   function automatic fraction_rsp_type evaluate_fraction_op(input fraction_req_type r);
      rau_pkg::rau_word_type an, ad, bn, bd, num, den, prod, up, down, x, y, t;
      logic                  reducible;
      fraction_rsp_type      res;
      an = rau_pkg::rau_word_type'(r.a_num);
      ad = rau_pkg::rau_word_type'(r.a_den);
      bn = rau_pkg::rau_word_type'(r.b_num);
      bd = rau_pkg::rau_word_type'(r.b_den);
      num = '0;
      den = '0;
      reducible = 1'b0;
      res = '0;
      case (r.code)
         rau_pkg::OP_ADD: begin
            num = an * bd + bn * ad;
            den = ad * bd;
            reducible = 1'b1;
         end
         rau_pkg::OP_SUB: begin
            num = an * bd - bn * ad;
            den = ad * bd;
            reducible = 1'b1;
         end
         rau_pkg::OP_MUL: begin
            num = an * bn;
            den = ad * bd;
            reducible = 1'b1;
         end
         rau_pkg::OP_DIV: begin
            num = an * bd;
            den = ad * bn;
            reducible = 1'b1;
         end
         rau_pkg::OP_MULI: begin
            num = an * bn;
            den = ad;
            reducible = 1'b1;
         end
         rau_pkg::OP_NEG: begin
            num = rau_pkg::rau_word_type'(0) - an;
            den = ad;
         end
         rau_pkg::OP_EQ: begin
            res.cmp_true = (ad == rau_pkg::rau_word_type'(1)) && (an == bn);
         end
         rau_pkg::OP_LT: begin
            prod = ad * bn;
            res.cmp_true = $signed(an) < $signed(prod);
         end
         rau_pkg::OP_GE: begin
            prod = ad * bn;
            res.cmp_true = !($signed(an) < $signed(prod));
         end
         default: ;
      endcase

      // gcd reduction on magnitudes, signs kept as computed
      if (reducible) begin
         up   = num[rau_pkg::WIDTH-1] ? rau_pkg::rau_word_type'(0) - num : num;
         down = den[rau_pkg::WIDTH-1] ? rau_pkg::rau_word_type'(0) - den : den;
         if (up != 0 && down == 0) begin
            res.zero_den_error = 1'b1;
         end else if (up != 0) begin
            x = up;
            y = down;
            while (y != 0) begin
               t = x % y;
               x = y;
               y = t;
            end
            num = num[rau_pkg::WIDTH-1] ? rau_pkg::rau_word_type'(0) - up / x : up / x;
            den = den[rau_pkg::WIDTH-1] ? rau_pkg::rau_word_type'(0) - down / x : down / x;
         end
      end
      res.res_num = rau_pkg::to_field(num);
      res.res_den = rau_pkg::to_field(den);
      return res;
   endfunction

   function automatic fraction_req_type make_req(input op_code_type code,
                                                 input logic signed [31:0] an,
                                                 input logic signed [31:0] ad,
                                                 input logic signed [31:0] bn,
                                                 input logic signed [31:0] bd);
      fraction_req_type r;
      r.code  = code;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (free_run || sel < 55) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // operand with a bias toward small values and shared factors
   function automatic logic signed [31:0] random_operand();
      int unsigned        sel;
      logic signed [31:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         v = int'($urandom_range(0, 40)) - 20;
      end else if (sel < 55) begin
         v = int'($urandom_range(1, 30)) * int'($urandom_range(1, 500));
         if ($urandom_range(0, 1)) v = -v;
      end else if (sel < 65) begin
         v = 32'sd1 <<< $urandom_range(0, 31);
         if ($urandom_range(0, 1)) v = -v;
      end else if (sel < 75) begin
         case ($urandom_range(0, 4))
            0:       v = MOST_NEG;
            1:       v = MOST_POS;
            2:       v = 32'sd0;
            3:       v = 32'sd1;
            default: v = -32'sd1;
         endcase
      end else begin
         v = $urandom();
      end
      return v;
   endfunction

   function automatic fraction_req_type random_req();
      op_code_type code;
      if ($urandom_range(0, 99) < 4)
         code = op_code_type'($urandom_range(int'(rau_pkg::OP_GE) + 1, OP_CODE_MAX));
      else
         code = op_code_type'($urandom_range(int'(rau_pkg::OP_ADD), int'(rau_pkg::OP_GE)));
      return make_req(code, random_operand(), random_operand(),
                      random_operand(), random_operand());
   endfunction

   // send one request word after an idle gap and log its expected response
   task automatic send_request(input fraction_req_type r, input int gap);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.req_type = r.code;
      req_bus.a_num    = r.a_num;
      req_bus.a_den    = r.a_den;
      req_bus.b_num    = r.b_num;
      req_bus.b_den    = r.b_den;
      req_bus.valid    = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(evaluate_fraction_op(r));
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic report_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0d (0x%h), got %0d (0x%h)", name,
                $signed(exp_val), exp_val, $signed(act_val), act_val);
         mismatch_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      fraction_rsp_type exp_rsp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response word with no request outstanding");
            mismatch_count++;
         end else begin
            exp_rsp = pending_results.pop_front();
            report_field("res_num", exp_rsp.res_num, rsp_bus.res_num);
            report_field("res_den", exp_rsp.res_den, rsp_bus.res_den);
            report_field("cmp_true", 32'(exp_rsp.cmp_true), 32'(rsp_bus.cmp_true));
            report_field("zero_den_error", 32'(exp_rsp.zero_den_error),
                         32'(rsp_bus.zero_den_error));
         end
      end
   end

   // response ready with random gaps and an on-demand long hold-off
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_req) begin
            stall_req = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end else begin
            hold = pick_gap();
            if (hold == 0) begin
               rsp_bus.ready = 1'b1;
            end else begin
               rsp_bus.ready = 1'b0;
               repeat (hold - 1) @(negedge clock);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // each operation at its corner values
   task automatic test_directed_corners();
      send_request(make_req(rau_pkg::OP_ADD, 1, 2, 1, 3), pick_gap());
      send_request(make_req(rau_pkg::OP_ADD, 1, 2, 1, 2), pick_gap());
      send_request(make_req(rau_pkg::OP_SUB, 1, 2, 1, 2), pick_gap());
      send_request(make_req(rau_pkg::OP_SUB, 1, -2, 1, 3), pick_gap());
      send_request(make_req(rau_pkg::OP_MUL, -2, 4, 3, 9), pick_gap());
      send_request(make_req(rau_pkg::OP_MUL, 0, 0, 7, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_DIV, 3, 4, 3, 8), pick_gap());
      send_request(make_req(rau_pkg::OP_DIV, 1, 2, 0, 5), pick_gap());
      send_request(make_req(rau_pkg::OP_DIV, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS),
                   pick_gap());
      send_request(make_req(rau_pkg::OP_MULI, 3, 7, 14, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_MULI, 5, 0, 2, 9), pick_gap());
      send_request(make_req(rau_pkg::OP_NEG, MOST_NEG, 3, 0, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_NEG, 5, -7, MOST_POS, MOST_NEG), pick_gap());
      send_request(make_req(rau_pkg::OP_EQ, 4, 1, 4, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_EQ, 4, 2, 2, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_LT, 1, 3, 1, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_LT, -5, 1, -5, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_GE, -5, 1, -5, 0), pick_gap());
      send_request(make_req(rau_pkg::OP_GE, MOST_NEG, MOST_POS, MOST_POS, -1),
                   pick_gap());
      send_request(make_req(rau_pkg::OP_ADD, MOST_NEG, 1, 0, 1), pick_gap());
      send_request(make_req(rau_pkg::OP_MUL, MOST_NEG, MOST_NEG, 1, 1), pick_gap());
      send_request(make_req(rau_pkg::OP_ADD, MOST_POS, 1, MOST_POS, 1), pick_gap());
      send_request(make_req(rau_pkg::OP_MUL, -1, -1, -1, -1), pick_gap());
      send_request(make_req(op_code_type'(int'(rau_pkg::OP_GE) + 1), 9, 9, 9, 9),
                   pick_gap());
      send_request(make_req(op_code_type'(OP_CODE_MAX), -1, -1, -1, -1), pick_gap());
   endtask

   // random mix with gaps on both channels
   task automatic test_random_mix(input int count);
      repeat (count) send_request(random_req(), pick_gap());
   endtask

   // back-to-back words with the response side always ready
   task automatic test_full_rate_stream(input int count);
      free_run = 1'b1;
      repeat (count) send_request(random_req(), 0);
      free_run = 1'b0;
   endtask

   // response held off long enough that the unit stops taking requests
   task automatic test_response_backpressure();
      stall_req = 1'b1;
      while (stall_req) @(negedge clock);
      repeat (8) send_request(random_req(), 0);
   endtask

   // sequence
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = '0;
      req_bus.a_num    = '0;
      req_bus.a_den    = '0;
      req_bus.b_num    = '0;
      req_bus.b_den    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_random_mix(RANDOM_WORDS / 2);
      test_response_backpressure();
      test_full_rate_stream(STREAM_WORDS);
      test_random_mix(RANDOM_WORDS / 2);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
